// File: design/frvm_pkg.sv
package frvm_pkg;
  localparam int MEM_DEPTH = 256;
  localparam int REG_COUNT = 5;
  localparam int PC_WIDTH = 16;
  localparam int AW = $clog2(MEM_DEPTH);
  localparam int RW = $clog2(REG_COUNT);

  typedef enum logic [4:0] {
    OP_NOP = 5'd0, OP_ADD = 5'd1, OP_MUL = 5'd2, OP_SUB = 5'd3, OP_DIV = 5'd4,
    OP_COPY = 5'd5, OP_LDI = 5'd6, OP_JMP = 5'd7, OP_JZ = 5'd8, OP_LT = 5'd9,
    OP_GT = 5'd10, OP_EQ = 5'd11, OP_PRINT = 5'd12, OP_ISTORE = 5'd13,
    OP_ADDR = 5'd14, OP_ILOAD = 5'd15, OP_RREAD = 5'd16, OP_RWRITE = 5'd17,
    OP_RET = 5'd18
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD1, S_RD2, S_RD3, S_RD4, S_DIV, S_MUL, S_EXEC, S_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] n;
    logic [31:0] d;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] q;
  } div_rsp_t;
endpackage

// File: design/frvm_if.sv
interface frvm_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  op;
  logic [15:0] operand_a;
  logic signed [31:0] operand_b;
  logic [15:0] operand_c;
  modport source (output valid, op, operand_a, operand_b, operand_c, input ready);
  modport sink (input valid, op, operand_a, operand_b, operand_c, output ready);
endinterface

interface frvm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_pc;
  logic        halted;
  logic        print_valid;
  logic signed [31:0] print_value;
  modport source (output valid, next_pc, halted, print_valid, print_value, input ready);
  modport sink (input valid, next_pc, halted, print_valid, print_value, output ready);
endinterface

interface frvm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: design/frvm_div.sv
module frvm_div (
  input  logic                clk,
  input  logic                rst,
  input  frvm_pkg::div_req_t  req,
  output frvm_pkg::div_rsp_t  rsp
);
  logic [31:0] rem, quo, dv;
  logic [5:0]  cnt;
  logic        busy, neg;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd32;
        rem <= '0;
        quo <= req.n[31] ? -req.n : req.n;
        dv <= req.d[31] ? -req.d : req.d;
        neg <= req.n[31] ^ req.d[31];
        if (req.d == '0) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
          rsp.q <= '0;
        end
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          rsp.done <= 1'b1;
          rsp.q <= neg ? -{quo[30:0], ~trial[32]} : {quo[30:0], ~trial[32]};
        end
      end
    end
  end
endmodule

// File: design/frvm_mem.sv
module frvm_mem (
  input  logic                    clk,
  input  logic                    we,
  input  logic [frvm_pkg::AW-1:0] waddr,
  input  logic [31:0]             wdata,
  input  logic [frvm_pkg::AW-1:0] raddr,
  output logic [31:0]             rdata
);
  logic [31:0] mem [frvm_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: design/frame_relative_memory_vm_execute.sv
// Frame-relative memory-to-memory instruction executor.
// Channels: in (one instruction per beat), out (one result beat per
// instruction), cfg (program_length write; always ready, so write it only
// while no instruction is in work).
// Each instruction reads up to three data-memory words through one
// synchronous read port, one read per cycle, then writes back at most one word.
// An instruction passes RD1 to RD4 and EXEC to the output state; a
// multiply adds a MUL state for the registered product, and a divide waits
// in DIV for the radix-2 iterative divider. One instruction is in work at
// a time; the next beat is taken only once the result has left the output.
// After reset the block runs a clearing pass over all 256 data-memory
// words (one word per cycle), during which in.ready is low; cfg writes
// are still taken. Registers and program counter clear at once.
// The result is held in the output register until out.ready; while the
// receiver stalls, no new instruction is accepted.
module frame_relative_memory_vm_execute (
  input logic         clk,
  input logic         rst,
  frvm_in_if.sink     in,
  frvm_out_if.source  out,
  frvm_cfg_if.sink    cfg
);
  localparam int AW = frvm_pkg::AW;
  localparam int PW = frvm_pkg::PC_WIDTH;

  frvm_pkg::state_t state, state_next;
  frvm_pkg::op_t    op;
  logic [15:0] a, c;
  logic [31:0] b, x, y, z;
  logic [31:0] regs [frvm_pkg::REG_COUNT];
  logic [PW-1:0] pc;
  logic [15:0] plen;
  logic [AW-1:0] clr;
  logic [31:0] prod;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;
  frvm_pkg::div_req_t dreq;
  frvm_pkg::div_rsp_t drsp;

  frvm_mem u_mem (.clk, .we, .waddr, .wdata, .raddr, .rdata);
  frvm_div u_div (.clk, .rst, .req(dreq), .rsp(drsp));

  function automatic logic [AW-1:0] fa(input logic [31:0] base, input logic [31:0] off);
    logic [31:0] s;
    s = base + off;
    return s[AW-1:0];
  endfunction

  assign in.ready = (state == frvm_pkg::S_IDLE);
  assign cfg.ready = 1'b1;

  // RD1 issues first read, RD2 captures x and issues second, RD3 captures y
  // and issues the third (indirect) read, RD4 captures the third word.
  always_comb begin
    state_next = state;
    case (state)
      frvm_pkg::S_CLEAR: if (clr == AW'(frvm_pkg::MEM_DEPTH - 1)) state_next = frvm_pkg::S_IDLE;
      frvm_pkg::S_IDLE: if (in.valid) state_next = frvm_pkg::S_RD1;
      frvm_pkg::S_RD1: state_next = frvm_pkg::S_RD2;
      frvm_pkg::S_RD2: state_next = frvm_pkg::S_RD3;
      frvm_pkg::S_RD3: state_next = frvm_pkg::S_RD4;
      frvm_pkg::S_RD4: begin
        if (op == frvm_pkg::OP_DIV) state_next = frvm_pkg::S_DIV;
        else if (op == frvm_pkg::OP_MUL) state_next = frvm_pkg::S_MUL;
        else state_next = frvm_pkg::S_EXEC;
      end
      frvm_pkg::S_DIV: if (drsp.done) state_next = frvm_pkg::S_EXEC;
      frvm_pkg::S_MUL: state_next = frvm_pkg::S_EXEC;
      frvm_pkg::S_EXEC: state_next = frvm_pkg::S_OUT;
      frvm_pkg::S_OUT: if (out.ready) state_next = frvm_pkg::S_IDLE;
      default: state_next = frvm_pkg::S_IDLE;
    endcase
  end

  logic [31:0] res;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  always_comb begin
    res = '0;
    wr_en = 1'b0;
    wr_addr = fa(regs[0], {16'd0, a});
    case (op)
      frvm_pkg::OP_ADD: begin res = x + y; wr_en = 1'b1; end
      frvm_pkg::OP_MUL: begin res = prod; wr_en = 1'b1; end
      frvm_pkg::OP_SUB: begin res = x - y; wr_en = 1'b1; end
      frvm_pkg::OP_DIV: begin res = z; wr_en = 1'b1; end
      frvm_pkg::OP_COPY: begin res = x; wr_en = 1'b1; end
      frvm_pkg::OP_LDI: begin res = b; wr_en = 1'b1; end
      frvm_pkg::OP_LT: begin res = {31'd0, $signed(x) < $signed(y)}; wr_en = 1'b1; end
      frvm_pkg::OP_GT: begin res = {31'd0, $signed(x) > $signed(y)}; wr_en = 1'b1; end
      frvm_pkg::OP_EQ: begin res = {31'd0, x == y}; wr_en = 1'b1; end
      frvm_pkg::OP_ISTORE: begin res = x; wr_en = 1'b1; wr_addr = y[AW-1:0]; end
      frvm_pkg::OP_ADDR: begin res = b + regs[0]; wr_en = 1'b1; end
      frvm_pkg::OP_ILOAD: begin res = z; wr_en = 1'b1; end
      frvm_pkg::OP_RREAD: begin
        res = (b < 32'(frvm_pkg::REG_COUNT)) ? regs[b[frvm_pkg::RW-1:0]] : '0;
        wr_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = clr;
    wdata = '0;
    raddr = fa(regs[0], b);
    case (state)
      frvm_pkg::S_CLEAR: we = 1'b1;
      frvm_pkg::S_RD1: raddr = (op == frvm_pkg::OP_JZ || op == frvm_pkg::OP_PRINT) ?
                               fa(regs[0], {16'd0, a}) : fa(regs[0], b);
      frvm_pkg::S_RD2: raddr = (op == frvm_pkg::OP_ISTORE) ? a[AW-1:0] :
                               fa(regs[0], {16'd0, c});
      frvm_pkg::S_RD3: raddr = x[AW-1:0];
      frvm_pkg::S_EXEC: begin
        we = wr_en;
        waddr = wr_addr;
        wdata = res;
      end
      default: ;
    endcase
  end

  assign dreq.start = (state == frvm_pkg::S_RD4) && (op == frvm_pkg::OP_DIV);
  assign dreq.n = x;
  assign dreq.d = y;

  logic [PW-1:0] pc_t;
  always_comb begin
    pc_t = pc;
    case (op)
      frvm_pkg::OP_JMP: pc_t = PW'(a);
      frvm_pkg::OP_JZ: if (x == '0) pc_t = b[PW-1:0];
      frvm_pkg::OP_RET: pc_t = regs[2][PW-1:0];
      default: ;
    endcase
  end

  logic [PW-1:0] pc_inc;
  assign pc_inc = pc_t + PW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frvm_pkg::S_CLEAR;
      clr <= '0;
      pc <= '0;
      plen <= '0;
      out.valid <= 1'b0;
      for (int i = 0; i < frvm_pkg::REG_COUNT; i++) regs[i] <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid) plen <= cfg.data;
      if (state == frvm_pkg::S_CLEAR) clr <= clr + AW'(1);
      if (state == frvm_pkg::S_EXEC) begin
        pc <= pc_inc;
        out.valid <= 1'b1;
        if (op == frvm_pkg::OP_RWRITE && {16'd0, a} < 32'(frvm_pkg::REG_COUNT))
          regs[a[frvm_pkg::RW-1:0]] <= x;
      end
      if (out.valid && out.ready) out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      op <= frvm_pkg::op_t'(in.op);
      a <= in.operand_a;
      b <= in.operand_b;
      c <= in.operand_c;
    end
    if (state == frvm_pkg::S_RD2) x <= rdata;
    if (state == frvm_pkg::S_RD3) y <= rdata;
    if (state == frvm_pkg::S_RD4) z <= rdata;
    if (state == frvm_pkg::S_DIV && drsp.done) z <= drsp.q;
    if (state == frvm_pkg::S_MUL) prod <= x * y;
    if (state == frvm_pkg::S_EXEC) begin
      out.next_pc <= pc_inc;
      out.halted <= (pc_inc >= plen);
      out.print_valid <= (op == frvm_pkg::OP_PRINT);
      out.print_value <= (op == frvm_pkg::OP_PRINT) ? x : '0;
    end
  end

  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> (state == frvm_pkg::S_OUT))
    else $error("result valid outside output state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != frvm_pkg::S_IDLE) |-> !in.ready)
    else $error("input ready while busy");
  a_print_zero: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.print_valid) |-> (out.print_value == '0))
    else $error("print value nonzero without print");
endmodule
